// ----- sv/mcsw_pkg.sv -----
// Shared types and constants for the motor command shaper with watchdog.
// Used by mcsw_cmd_decode and motor_command_shaper_with_watchdog.
// No dependencies.
`default_nettype none

package mcsw_pkg;

  // Command codes (input tuser)
  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_STOP = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Motor kinds
  localparam logic [1:0] KIND_SERVO   = 2'd0;
  localparam logic [1:0] KIND_HBRIDGE = 2'd1;

  // Register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_KIND    = 3'd0;
  localparam logic [2:0] REG_INVERT  = 3'd1;
  localparam logic [2:0] REG_BRAKE   = 3'd2;
  localparam logic [2:0] REG_CAP     = 3'd3;
  localparam logic [2:0] REG_PMIN    = 3'd4;
  localparam logic [2:0] REG_PMAX    = 3'd5;
  localparam logic [2:0] REG_NEUTRAL = 3'd6;
  localparam logic [2:0] REG_TIMEOUT = 3'd7;

  // Register reset values
  localparam logic [15:0] PMIN_RST    = 16'd1000;
  localparam logic [15:0] PMAX_RST    = 16'd2000;
  localparam logic [15:0] NEUTRAL_RST = 16'd1500;

  // Speed scaling
  localparam logic signed [13:0] SPEED_FULL = 14'sd1000;
  localparam logic [13:0]        CAP_SCALE  = 14'd10;

  // Divide by 1000: q = (p * RECIP_MULT) >> RECIP_SHIFT, exact for p < 2^28
  localparam int              PROD_W      = 29;
  localparam int              Q_W         = 19;
  localparam int              RECIP_SHIFT = 38;
  localparam logic [28:0]     RECIP_MULT  = 29'd274877907;

  typedef struct packed {
    logic [1:0]  motor_kind;
    logic        invert_direction;
    logic        brake_enable;
    logic [9:0]  speed_cap_hundredths;
    logic [15:0] pulse_min_us;
    logic [15:0] pulse_max_us;
    logic [15:0] pulse_neutral_us;
    logic [31:0] watchdog_limit;
  } mcsw_cfg_t;

  // Decoded command, carried down the pipeline
  typedef struct packed {
    logic              status;
    logic              drive_update;
    logic              servo_map;     // pulse comes from the scaled product
    logic              neg;           // sign of the servo offset
    logic [PROD_W-1:0] prod;          // |speed| * half span
    logic [15:0]       pulse_us;      // fixed pulse for a stop
    logic [9:0]        duty_permille;
    logic              forward;
    logic              brake;
  } mcsw_stage_t;

endpackage

`default_nettype wire

// ----- sv/mcsw_cmd_decode.sv -----
// Command decode: watchdog check, stop handling, H-bridge duty and servo product.
// Purely combinational; depends on mcsw_pkg.
`default_nettype none

module mcsw_cmd_decode (
  input  wire logic [1:0]          cmd,
  input  wire logic [12:0]         speed_milli,
  input  wire logic [31:0]         time_ms,
  input  wire logic [31:0]         last_time,
  input  wire mcsw_pkg::mcsw_cfg_t cfg,
  output mcsw_pkg::mcsw_stage_t    stage,
  output logic                     load_time
);
  import mcsw_pkg::*;

  logic signed [13:0] spd_ext;
  logic signed [13:0] spd_dir;
  logic signed [14:0] spd_wide;
  logic [13:0]        cap_val;
  logic signed [14:0] cap_s;
  logic signed [14:0] spd_cap;
  logic signed [14:0] spd_abs;
  logic [12:0]        srv_mag;
  logic signed [16:0] span;
  logic signed [16:0] half_s;
  logic [15:0]        half;
  logic signed [13:0] hb_spd;
  logic signed [13:0] hb_abs;
  logic [31:0]        elapsed;
  logic               tick_fire;
  logic               stop_like;
  logic               kind_drives;

  // Sign-extend and apply direction inversion
  assign spd_ext  = $signed({speed_milli[12], speed_milli});
  assign spd_dir  = cfg.invert_direction ? -spd_ext : spd_ext;
  assign spd_wide = $signed({spd_dir[13], spd_dir});

  // Servo speed cap, in thousandths
  assign cap_val = 14'(cfg.speed_cap_hundredths) * CAP_SCALE;
  assign cap_s   = $signed({1'b0, cap_val});

  always_comb begin
    spd_cap = spd_wide;
    if (cap_val != '0) begin
      if (spd_wide > cap_s) begin
        spd_cap = cap_s;
      end else if (spd_wide < -cap_s) begin
        spd_cap = -cap_s;
      end
    end
  end

  assign spd_abs = spd_cap[14] ? -spd_cap : spd_cap;
  assign srv_mag = spd_abs[12:0];

  // Half span, truncated toward zero, kept modulo 2^16
  assign span   = $signed({1'b0, cfg.pulse_max_us}) - $signed({1'b0, cfg.pulse_min_us});
  assign half_s = span[16] ? ((span + 17'sd1) >>> 1) : (span >>> 1);
  assign half   = half_s[15:0];

  // H-bridge clamp to full speed either way
  always_comb begin
    hb_spd = spd_dir;
    if (spd_dir > SPEED_FULL) begin
      hb_spd = SPEED_FULL;
    end else if (spd_dir < -SPEED_FULL) begin
      hb_spd = -SPEED_FULL;
    end
  end

  assign hb_abs = hb_spd[13] ? -hb_spd : hb_spd;

  // Watchdog: elapsed time wraps modulo 2^32
  assign elapsed     = time_ms - last_time;
  assign tick_fire   = (cfg.watchdog_limit != '0) && (elapsed > cfg.watchdog_limit);
  assign stop_like   = (cmd == CMD_STOP) || ((cmd == CMD_TICK) && tick_fire);
  assign kind_drives = (cfg.motor_kind == KIND_SERVO) || (cfg.motor_kind == KIND_HBRIDGE);
  assign load_time   = ((cmd == CMD_SET) && kind_drives) || stop_like;

  // Build the result fields
  always_comb begin
    stage      = '0;
    stage.neg  = spd_cap[14];
    stage.prod = PROD_W'(srv_mag) * PROD_W'(half);
    if (cmd == CMD_SET) begin
      case (cfg.motor_kind)
        KIND_SERVO: begin
          stage.drive_update = 1'b1;
          stage.servo_map    = 1'b1;
        end
        KIND_HBRIDGE: begin
          stage.drive_update  = 1'b1;
          stage.duty_permille = hb_abs[9:0];
          stage.forward       = ~hb_spd[13];
          stage.brake         = cfg.brake_enable;
        end
        default: begin
          stage.status = 1'b1;
        end
      endcase
    end else if (stop_like) begin
      if ((cfg.motor_kind == KIND_SERVO) && (cfg.pulse_neutral_us != '0)) begin
        stage.drive_update = 1'b1;
        stage.pulse_us     = cfg.pulse_neutral_us;
      end else if (cfg.motor_kind == KIND_HBRIDGE) begin
        stage.drive_update = 1'b1;
        stage.forward      = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/motor_command_shaper_with_watchdog.sv -----
// Motor command shaper with command watchdog, one motor channel.
// Top level: input register, decode, divide-by-1000 and clamp stages, output register.
// Depends on mcsw_pkg and mcsw_cmd_decode.
//
// Usage:
//   s_* stream: one command per transaction. s_tuser = command (set speed, stop,
//   tick); s_tdata = speed_milli [12:0], time_ms [44:13].
//   m_* stream: one result per command, in order. m_tuser = status [0],
//   drive_update [1]; m_tdata = pulse_us, duty_permille, forward, brake.
//   APB port: eight 32-bit registers at byte address 4*i, pready tied high.
//   Write registers only while the block is idle.
// Timing:
//   Four-register pipeline: input, decode, divide and output registers.
//   One command per cycle sustained while m_tready allows; the watchdog timestamp is
//   compared and updated in the decode stage, so commands follow back to back.
//   The two multiplies (speed times half span, then the reciprocal of 1000)
//   each own a stage.
// Reset: synchronous; registers return to their defaults, the last command
//   time clears and the pipeline empties.
// Stall: each stage holds while the one after it is full and stalled; the
//   input keeps accepting until every stage is occupied.
`default_nettype none

module motor_command_shaper_with_watchdog (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // speed_milli[12:0], time_ms[44:13], zero[47:45]
  input  wire logic [1:0]  s_tuser,   // command[1:0]
  // Output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // pulse_us[15:0], duty_permille[25:16],
                                      // forward[26], brake[27], zero[31:28]
  output logic [1:0]       m_tuser,   // status[0], drive_update[1]
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mcsw_pkg::*;

  mcsw_cfg_t   cfg;
  logic [31:0] last_time;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  // Pipeline stages
  logic        v0, v1, v2;
  logic        adv0, adv1, adv2, adv3;
  logic [1:0]  in_cmd;
  logic [12:0] in_speed;
  logic [31:0] in_time;

  mcsw_stage_t dec_stage;
  logic        dec_load;
  mcsw_stage_t st1;
  mcsw_stage_t st2;
  logic [Q_W-1:0] q2;
  logic [57:0]    recip_prod;

  logic signed [20:0] us_sum;
  logic signed [20:0] us_clamp;
  logic signed [20:0] q_signed;
  logic signed [20:0] pmin_s;
  logic signed [20:0] pmax_s;
  logic [15:0]        pulse_next;

  logic        out_status;
  logic        out_update;
  logic [15:0] out_pulse;
  logic [9:0]  out_duty;
  logic        out_fwd;
  logic        out_brk;

  // ---------------- Configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.motor_kind           <= KIND_SERVO;
      cfg.invert_direction     <= 1'b0;
      cfg.brake_enable         <= 1'b0;
      cfg.speed_cap_hundredths <= '0;
      cfg.pulse_min_us         <= PMIN_RST;
      cfg.pulse_max_us         <= PMAX_RST;
      cfg.pulse_neutral_us     <= NEUTRAL_RST;
      cfg.watchdog_limit       <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_KIND:    cfg.motor_kind           <= pwdata[1:0];
        REG_INVERT:  cfg.invert_direction     <= pwdata[0];
        REG_BRAKE:   cfg.brake_enable         <= pwdata[0];
        REG_CAP:     cfg.speed_cap_hundredths <= pwdata[9:0];
        REG_PMIN:    cfg.pulse_min_us         <= pwdata[15:0];
        REG_PMAX:    cfg.pulse_max_us         <= pwdata[15:0];
        REG_NEUTRAL: cfg.pulse_neutral_us     <= pwdata[15:0];
        REG_TIMEOUT: cfg.watchdog_limit       <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (reg_idx)
      REG_KIND:    prdata = 32'(cfg.motor_kind);
      REG_INVERT:  prdata = 32'(cfg.invert_direction);
      REG_BRAKE:   prdata = 32'(cfg.brake_enable);
      REG_CAP:     prdata = 32'(cfg.speed_cap_hundredths);
      REG_PMIN:    prdata = 32'(cfg.pulse_min_us);
      REG_PMAX:    prdata = 32'(cfg.pulse_max_us);
      REG_NEUTRAL: prdata = 32'(cfg.pulse_neutral_us);
      REG_TIMEOUT: prdata = cfg.watchdog_limit;
      default:     prdata = '0;
    endcase
  end

  // ---------------- Flow control ----------------
  // Advance a stage when the next one is empty or moving
  assign adv3     = ~m_tvalid | m_tready;
  assign adv2     = ~v2 | adv3;
  assign adv1     = ~v1 | adv2;
  assign adv0     = ~v0 | adv1;
  assign s_tready = adv0;

  // ---------------- Stage 0: input register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv0) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && s_tvalid) begin
      in_cmd   <= s_tuser;
      in_speed <= s_tdata[12:0];
      in_time  <= s_tdata[44:13];
    end
  end

  // ---------------- Stage 1: decode and watchdog ----------------
  mcsw_cmd_decode u_decode (
    .cmd         (in_cmd),
    .speed_milli (in_speed),
    .time_ms     (in_time),
    .last_time   (last_time),
    .cfg         (cfg),
    .stage       (dec_stage),
    .load_time   (dec_load)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      last_time <= '0;
    end else if (adv1) begin
      v1 <= v0;
      if (v0 && dec_load) begin
        last_time <= in_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && v0) begin
      st1 <= dec_stage;
    end
  end

  // ---------------- Stage 2: divide product by 1000 ----------------
  assign recip_prod = 58'(st1.prod) * 58'(RECIP_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      st2 <= st1;
      q2  <= recip_prod[RECIP_SHIFT +: Q_W];
    end
  end

  // ---------------- Stage 3: offset, clamp, output register ----------------
  assign q_signed = $signed({2'b00, q2});
  assign us_sum   = $signed({5'b00000, cfg.pulse_neutral_us}) + (st2.neg ? -q_signed : q_signed);
  assign pmin_s   = $signed({5'b00000, cfg.pulse_min_us});
  assign pmax_s   = $signed({5'b00000, cfg.pulse_max_us});

  // Clamp up to min first, then down to max, so max wins
  always_comb begin
    us_clamp = us_sum;
    if (us_clamp < pmin_s) begin
      us_clamp = pmin_s;
    end
    if (us_clamp > pmax_s) begin
      us_clamp = pmax_s;
    end
  end

  assign pulse_next = st2.servo_map ? us_clamp[15:0] : st2.pulse_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv3) begin
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      out_status <= st2.status;
      out_update <= st2.drive_update;
      out_pulse  <= pulse_next;
      out_duty   <= st2.duty_permille;
      out_fwd    <= st2.forward;
      out_brk    <= st2.brake;
    end
  end

  assign m_tuser = {out_update, out_status};
  assign m_tdata = {4'b0000, out_brk, out_fwd, out_duty, out_pulse};

  // ---------------- Assertions ----------------
  // A refused command never carries a drive update
  a_refused_no_drive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_status && out_update))
    else $error("refused command flagged as drive update");

  // A servo pulse and H-bridge fields are never both set
  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_pulse != '0) |-> (out_duty == '0 && !out_fwd && !out_brk))
    else $error("servo pulse mixed with H-bridge drive");

  // Duty stays within full scale
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_duty <= 10'd1000))
    else $error("duty above full scale");

  // Accepted command lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v0)
    else $error("accepted command lost at input register");

  // Timestamp only moves when a command leaves the input register
  a_time_moves: assert property (@(posedge clk) disable iff (rst)
    !$past(v0 && adv1) |-> $stable(last_time))
    else $error("last command time changed without a command");

endmodule

`default_nettype wire
